>>> sv/ism_pkg.sv
package ism_pkg;

    // Field widths
    localparam int OPCODE_W            = 4;
    localparam int DATA_W              = 32;
    localparam int DEPTH_W             = 11;
    localparam int STATUS_W            = 2;
    localparam int DEFAULT_STACK_DEPTH = 1024;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Instruction codes
    localparam opcode_t OP_CONST = 4'd0;
    localparam opcode_t OP_ADD   = 4'd1;
    localparam opcode_t OP_SUB   = 4'd2;
    localparam opcode_t OP_MUL   = 4'd3;
    localparam opcode_t OP_DIV   = 4'd4;
    localparam opcode_t OP_MAX   = 4'd5;
    localparam opcode_t OP_MIN   = 4'd6;
    localparam opcode_t OP_NEG   = 4'd7;
    localparam opcode_t OP_DUP   = 4'd8;
    localparam opcode_t OP_SWAP  = 4'd9;
    localparam opcode_t OP_END   = 4'd10;

    // Result status codes
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_UNDER = 2'd1;
    localparam status_t STAT_OVER  = 2'd2;
    localparam status_t STAT_DIV0  = 2'd3;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    start;
        opcode_t op;
    } alu_cmd_t;

    // Answer from the arithmetic unit
    typedef struct packed {
        logic  done;
        data_t result;
    } alu_rsp_t;

endpackage

>>> sv/ism_alu.sv
module ism_alu (
    input  logic             clk,
    input  logic             rst_n,
    input  ism_pkg::alu_cmd_t cmd,
    input  ism_pkg::data_t   a,
    input  ism_pkg::data_t   b,
    output ism_pkg::alu_rsp_t rsp
);
    import ism_pkg::*;

    localparam int DIV_STEPS = DATA_W;
    localparam int CW        = $clog2(DIV_STEPS);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_FIX  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic            done_reg, done_next;
    data_t           res_reg, res_next;
    data_t           rem_reg, rem_next;
    data_t           quo_reg, quo_next;
    data_t           dvs_reg, dvs_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    data_t           add_a, add_b, sum;
    logic            add_cin;
    data_t           prod;
    logic            a_ge_b;
    data_t           a_abs, b_abs;
    logic [DATA_W:0] rem_sh, rem_diff;
    logic            rem_ge;

    // Shared adder: add, subtract and negate
    always_comb
    begin
        add_a   = a;
        add_b   = b;
        add_cin = 1'b0;
        case (cmd.op)
            OP_SUB:
            begin
                add_b   = ~b;
                add_cin = 1'b1;
            end
            OP_NEG:
            begin
                add_a   = '0;
                add_b   = ~a;
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = a;
            end
        endcase
    end

    assign sum    = add_a + add_b + DATA_W'(add_cin);
    assign prod   = a * b;
    assign a_ge_b = $signed(a) >= $signed(b);
    assign a_abs  = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    assign b_abs  = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

    // One restoring division step per cycle
    assign rem_sh   = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign rem_ge   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op)
                        OP_ADD, OP_SUB, OP_NEG:
                        begin
                            res_next  = sum;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            res_next  = prod;
                            done_next = 1'b1;
                        end
                        OP_MAX:
                        begin
                            res_next  = a_ge_b ? a : b;
                            done_next = 1'b1;
                        end
                        OP_MIN:
                        begin
                            res_next  = a_ge_b ? b : a;
                            done_next = 1'b1;
                        end
                        OP_DIV:
                        begin
                            rem_next   = '0;
                            quo_next   = a_abs;
                            dvs_next   = b_abs;
                            neg_next   = a[DATA_W-1] ^ b[DATA_W-1];
                            cnt_next   = '0;
                            state_next = A_DIV;
                        end
                        default:
                        begin
                            res_next  = a;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                rem_next = rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], rem_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                // Apply the quotient sign
                res_next   = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

>>> sv/integer_stack_machine.sv
// Stack-machine interpreter on a 32-bit signed operand stack.
// Input channel: in_valid / in_stall with opcode and operand_value; one
// instruction is taken per item. Output channel: out_valid / out_stall with
// top_value, stack_depth, status and program_end; exactly one result item
// per instruction, in order.
// The block works on one instruction at a time: in_stall is high from the
// cycle after an item is taken until its result has moved into the output
// register. CONST, DUP, END, unknown codes and every error pass through
// DECODE and then FINISH; SWAP goes DECODE, SWAP, FINISH (two stack writes
// through the single memory write port); ADD, SUB, MUL, MAX, MIN, NEG and DIV
// go DECODE, EXEC, FINISH, and DIV stays in EXEC while the shared arithmetic
// unit's divider resolves one quotient bit per cycle. No new item is taken
// until the previous result has moved into the output register.
// The next item is taken while a finished result waits in the output
// register; if out_stall holds that result, the following result waits in
// its final state and in_stall stays high.
// Reset empties the stack (depth zero) and drops any pending result. The
// stack memory is not cleared: only entries below the depth are ever used.
module integer_stack_machine #(
    parameter int STACK_DEPTH = ism_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  ism_pkg::opcode_t        opcode,
    input  logic signed [31:0]      operand_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      top_value,
    output logic [10:0]             stack_depth,
    output ism_pkg::status_t        status,
    output logic                    program_end
);
    import ism_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SWAP   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      sp_reg, sp_next;
    data_t              top_reg, top_next;
    opcode_t            op_reg, op_next;
    data_t              x_reg, x_next;
    status_t            stat_reg, stat_next;
    logic               end_reg, end_next;
    logic               out_valid_reg, out_valid_next;
    data_t              out_top_reg, out_top_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;
    status_t            out_status_reg, out_status_next;
    logic               out_end_reg, out_end_next;
    data_t              rd_data_reg;

    data_t              stack_mem [STACK_DEPTH];

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    data_t              wr_data;
    logic [PW-1:0]      sp_dec1, sp_dec2;
    logic [AW-1:0]      sp_lo, sp_m1, sp_m2;
    logic [DEPTH_W+PW-1:0] sp_ext;
    logic               is_empty, is_full, below_two, out_load;
    alu_cmd_t           alu_cmd;
    alu_rsp_t           alu_rsp;

    assign sp_dec1   = sp_reg - PW'(1);
    assign sp_dec2   = sp_reg - PW'(2);
    assign sp_lo     = sp_reg[AW-1:0];
    assign sp_m1     = sp_dec1[AW-1:0];
    assign sp_m2     = sp_dec2[AW-1:0];
    assign sp_ext    = {{DEPTH_W{1'b0}}, sp_reg};
    assign is_empty  = sp_reg == '0;
    assign is_full   = sp_reg == PW'(STACK_DEPTH);
    assign below_two = sp_reg < PW'(2);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    ism_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .a     (top_reg),
        .b     (rd_data_reg),
        .rsp   (alu_rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        stat_next       = stat_reg;
        end_next        = end_reg;
        wr_en           = 1'b0;
        wr_addr         = sp_lo;
        wr_data         = top_reg;
        alu_cmd.start   = 1'b0;
        alu_cmd.op      = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    x_next     = operand_value;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                stat_next  = STAT_OK;
                end_next   = 1'b0;
                state_next = S_FINISH;
                case (op_reg)
                    OP_CONST:
                    begin
                        if (is_full)
                        begin
                            stat_next = STAT_OVER;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = sp_lo;
                            wr_data  = x_reg;
                            top_next = x_reg;
                            sp_next  = sp_reg + PW'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_MAX, OP_MIN:
                    begin
                        if (below_two)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            state_next    = S_EXEC;
                        end
                    end
                    OP_DIV:
                    begin
                        if (below_two)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else if (rd_data_reg == '0)
                        begin
                            stat_next = STAT_DIV0;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            state_next    = S_EXEC;
                        end
                    end
                    OP_NEG:
                    begin
                        if (is_empty)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            state_next    = S_EXEC;
                        end
                    end
                    OP_DUP:
                    begin
                        if (is_empty)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else if (is_full)
                        begin
                            stat_next = STAT_OVER;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = sp_lo;
                            wr_data = top_reg;
                            sp_next = sp_reg + PW'(1);
                        end
                    end
                    OP_SWAP:
                    begin
                        if (below_two)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        else
                        begin
                            // Old top goes down; second entry becomes the top
                            wr_en      = 1'b1;
                            wr_addr    = sp_m2;
                            wr_data    = top_reg;
                            top_next   = rd_data_reg;
                            state_next = S_SWAP;
                        end
                    end
                    OP_END:
                    begin
                        end_next = 1'b1;
                        if (is_empty)
                        begin
                            stat_next = STAT_UNDER;
                        end
                        sp_next = '0;
                    end
                    default:
                    begin
                        stat_next = STAT_OK;
                    end
                endcase
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    top_next   = alu_rsp.result;
                    wr_en      = 1'b1;
                    wr_data    = alu_rsp.result;
                    state_next = S_FINISH;
                    if (op_reg == OP_NEG)
                    begin
                        wr_addr = sp_m1;
                    end
                    else
                    begin
                        wr_addr = sp_m2;
                        sp_next = sp_dec1;
                    end
                end
            end
            S_SWAP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sp_m1;
                wr_data    = top_reg;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: hold while stalled, load when the slot frees up
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        out_end_next    = out_end_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_depth_next  = sp_ext[DEPTH_W-1:0];
            out_status_next = stat_reg;
            out_end_next    = end_reg;
            if (end_reg ? (stat_reg == STAT_UNDER) : is_empty)
            begin
                out_top_next = '0;
            end
            else
            begin
                out_top_next = top_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        op_reg         <= op_next;
        x_reg          <= x_next;
        stat_reg       <= stat_next;
        end_reg        <= end_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
        out_end_reg    <= out_end_next;
    end

    // Stack memory: one write port, one registered read of the second entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[sp_m2];
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign top_value   = out_top_reg;
    assign stack_depth = out_depth_reg;
    assign status      = out_status_reg;
    assign program_end = out_end_reg;

    // Checks
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted item did not move to decode");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_alu_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_EXEC))
        else $error("arithmetic result arrived outside execute");

    a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_depth_reg == '0))
        else $error("END result with non-zero depth");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import ism_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_LIMIT = 10;
    localparam data_t INT_MIN = 32'h8000_0000;
    localparam data_t INT_MAX = 32'h7fff_ffff;

    // Expected outcome of one instruction
    typedef struct packed {
        data_t       top;
        logic [10:0] depth;
        status_t     stat;
        logic        is_end;
    } machine_result_t;

    // Tracks the operand stack and checks each result item in order
    class stack_scoreboard;
        data_t           stack_mem [STACK_DEPTH];
        int unsigned     depth;
        machine_result_t pending_results [$];
        int unsigned     error_count;

        function new();
            depth       = 0;
            error_count = 0;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function data_t trunc_divide(data_t a, data_t b);
            data_t ua;
            data_t ub;
            data_t q;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q  = ua / ub;
            return (a[31] ^ b[31]) ? -q : q;
        endfunction

        // Execute one accepted instruction and queue the result it must give
        function void note_instruction(opcode_t op, data_t value);
            data_t           a;
            data_t           b;
            data_t           r;
            machine_result_t res;
            res.stat   = STAT_OK;
            res.is_end = 1'b0;
            a = (depth >= 1) ? stack_mem[depth-1] : '0;
            b = (depth >= 2) ? stack_mem[depth-2] : '0;
            case (op)
                OP_CONST:
                begin
                    if (depth >= STACK_DEPTH)
                        res.stat = STAT_OVER;
                    else
                    begin
                        stack_mem[depth] = value;
                        depth++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN:
                begin
                    if (depth < 2)
                        res.stat = STAT_UNDER;
                    else if (op == OP_DIV && b == '0)
                        res.stat = STAT_DIV0;
                    else
                    begin
                        case (op)
                            OP_ADD:  r = a + b;
                            OP_SUB:  r = a - b;
                            OP_MUL:  r = a * b;
                            OP_DIV:  r = trunc_divide(a, b);
                            OP_MAX:  r = ($signed(a) >= $signed(b)) ? a : b;
                            default: r = ($signed(a) >= $signed(b)) ? b : a;
                        endcase
                        stack_mem[depth-2] = r;
                        depth--;
                    end
                end
                OP_NEG:
                begin
                    if (depth < 1)
                        res.stat = STAT_UNDER;
                    else
                        stack_mem[depth-1] = -a;
                end
                OP_DUP:
                begin
                    if (depth < 1)
                        res.stat = STAT_UNDER;
                    else if (depth >= STACK_DEPTH)
                        res.stat = STAT_OVER;
                    else
                    begin
                        stack_mem[depth] = a;
                        depth++;
                    end
                end
                OP_SWAP:
                begin
                    if (depth < 2)
                        res.stat = STAT_UNDER;
                    else
                    begin
                        stack_mem[depth-1] = b;
                        stack_mem[depth-2] = a;
                    end
                end
                OP_END:
                begin
                    res.is_end = 1'b1;
                    if (depth == 0)
                        res.stat = STAT_UNDER;
                end
                default: ;
            endcase
            // report the top before END empties the stack
            res.top = (depth == 0) ? '0 : stack_mem[depth-1];
            if (op == OP_END)
                depth = 0;
            res.depth = 11'(depth);
            pending_results.push_back(res);
        endfunction

        // Compare one result item with the oldest expectation
        function void check_result(data_t top, logic [10:0] dep, status_t stat, logic is_end);
            machine_result_t want;
            if (pending_results.size() == 0)
            begin
                flag("unexpected result item", '0, top);
                return;
            end
            want = pending_results.pop_front();
            if (top !== want.top)
                flag("top_value", want.top, top);
            if (dep !== want.depth)
                flag("stack_depth", 32'(want.depth), 32'(dep));
            if (stat !== want.stat)
                flag("status", 32'(want.stat), 32'(stat));
            if (is_end !== want.is_end)
                flag("program_end", 32'(want.is_end), 32'(is_end));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    opcode_t            opcode = OP_CONST;
    logic signed [31:0] operand_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] top_value;
    logic [10:0]        stack_depth;
    status_t            status;
    logic               program_end;

    int unsigned        send_gap_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        cycle_count = 0;
    stack_scoreboard    sb = new();

    integer_stack_machine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .top_value     (top_value),
        .stack_depth   (stack_depth),
        .status        (status),
        .program_end   (program_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Check every result item taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(top_value, stack_depth, status, program_end);
    end

    // Abandon a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[integer_stack_machine] ERROR");
            $finish;
        end
    end

    // Small values are common so that division and comparisons give varied results
    function automatic data_t rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return data_t'($urandom_range(0, 16)) - data_t'(8);
            4:          return INT_MIN;
            5:          return INT_MAX;
            default:    return data_t'($urandom());
        endcase
    endfunction

    // Offer one instruction item and hold it until taken; call at a falling edge
    task automatic send_item(input opcode_t op, input data_t value);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_gap_pct)
                @(negedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        operand_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_instruction(op, value);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned send_pcts [4];
        int unsigned stall_pcts [4];
        int unsigned pick;
        int unsigned target;
        opcode_t     op;

        send_pcts  = '{0, 87, 0, 12};
        stall_pcts = '{0, 0, 87, 12};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Underflow on an empty stack, END on an empty stack
        send_item(OP_ADD, '0);
        send_item(OP_NEG, INT_MAX);
        send_item(OP_DUP, '1);
        send_item(OP_END, INT_MIN);
        // Wrap on ADD, SWAP underflow, NEG of the most negative value
        send_item(OP_CONST, INT_MAX);
        send_item(OP_SWAP, '0);
        send_item(OP_DUP, '0);
        send_item(OP_ADD, '0);
        send_item(OP_CONST, INT_MIN);
        send_item(OP_NEG, '0);
        send_item(OP_END, '0);
        // Most negative over minus one, then divide by zero
        send_item(OP_CONST, '1);
        send_item(OP_CONST, INT_MIN);
        send_item(OP_DIV, '0);
        send_item(OP_CONST, '0);
        send_item(OP_SWAP, '0);
        send_item(OP_DIV, '0);
        send_item(OP_SUB, '0);
        send_item(OP_CONST, 32'd5);
        send_item(OP_MUL, '0);
        send_item(OP_CONST, -32'sd7);
        send_item(OP_MAX, '0);
        send_item(OP_CONST, 32'd3);
        send_item(OP_MIN, '0);
        send_item(OP_CONST, 32'd2);
        send_item(OP_CONST, -32'sd7);
        send_item(OP_DIV, '0);
        // Unknown opcodes do nothing
        send_item(opcode_t'(15), '1);
        send_item(opcode_t'(11), '0);
        send_item(OP_END, '0);

        // Random programs that climb to a full stack, a quarter per idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            send_gap_pct = send_pcts[ph];
            stall_pct    = stall_pcts[ph];
            target       = (ph == 3) ? STACK_DEPTH : (ph + 1) * (STACK_DEPTH / 4);
            while (sb.depth < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    op = opcode_t'($urandom_range(1, 15));
                    if (op == OP_END)
                        op = OP_SWAP;
                end
                else if (pick < 90)
                    op = OP_CONST;
                else
                    op = OP_DUP;
                send_item(op, rand_operand());
            end
        end

        // Overflow on CONST and DUP, then work on a full stack
        send_item(OP_CONST, INT_MAX);
        send_item(OP_DUP, '0);
        send_item(OP_SWAP, '0);
        send_item(OP_ADD, '0);
        send_item(OP_DUP, '0);
        send_item(OP_NEG, '0);
        send_item(OP_END, '0);
        in_valid <= 1'b0;

        // Drain and let any stray result appear
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("[integer_stack_machine] OK");
        else
            $display("[integer_stack_machine] ERROR");
        $finish;
    end

endmodule
